// ===== src/dj_pkg.sv =====
`timescale 1ns / 1ps

package dj_pkg;

    localparam int DEF_HORIZON = 1023;

    localparam int PROFIT_W   = 16;
    localparam int DEADLINE_W = 16;
    localparam int DURATION_W = 10;
    localparam int BEST_W     = 32;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DONE
    } dj_state_t;

    // control from the sequencer to the row sweep
    typedef struct packed {
        logic start;
        logic fresh;
    } dj_sweep_ctl_t;

    // status from the row sweep back to the sequencer
    typedef struct packed {
        logic last_issue;
        logic top_wr;
    } dj_sweep_sts_t;

endpackage

// ===== src/dj_ram.sv =====
`timescale 1ns / 1ps

module dj_ram #(
    parameter int WIDTH = dj_pkg::BEST_W,
    parameter int DEPTH = dj_pkg::DEF_HORIZON + 1
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a_reg <= mem[raddr_a];
        rdata_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

// ===== src/dj_sweep.sv =====
`timescale 1ns / 1ps

module dj_sweep #(
    parameter int HORIZON = dj_pkg::DEF_HORIZON
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  dj_pkg::dj_sweep_ctl_t             ctl,
    input  logic [dj_pkg::PROFIT_W-1:0]       profit,
    input  logic [$clog2(HORIZON+1)-1:0]      deadline,
    input  logic [dj_pkg::DURATION_W-1:0]     duration,
    output dj_pkg::dj_sweep_sts_t             sts,
    output logic [dj_pkg::BEST_W-1:0]         top_value
);

    localparam int DEPTH = HORIZON + 1;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CMP_W = (IDX_W > dj_pkg::DURATION_W) ? IDX_W : dj_pkg::DURATION_W;
    localparam int BW    = dj_pkg::BEST_W;

    logic             active_reg, active_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic             fresh_reg, fresh_next;

    logic             p1_valid_reg;
    logic [IDX_W-1:0] p1_idx_reg;
    logic             p1_use_reg;

    logic [IDX_W-1:0] lim;
    logic [CMP_W-1:0] t_full;
    logic             use_slot;

    logic [BW-1:0]    rd_j;
    logic [BW-1:0]    rd_t;
    logic [BW-1:0]    old_val;
    logic [BW-1:0]    base_val;
    logic [BW:0]      sum;
    logic [BW-1:0]    cand;
    logic [BW-1:0]    new_val;

    // issue stage: slot index counts down from the horizon
    always_comb begin
        active_next = active_reg;
        j_next      = j_reg;
        fresh_next  = fresh_reg;
        if (ctl.start) begin
            active_next = 1'b1;
            j_next      = IDX_W'(HORIZON);
            fresh_next  = ctl.fresh;
        end else if (active_reg) begin
            j_next = j_reg - 1'b1;
            if (j_reg == '0) begin
                active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg   <= 1'b0;
            fresh_reg    <= 1'b1;
            p1_valid_reg <= 1'b0;
        end else begin
            active_reg   <= active_next;
            fresh_reg    <= fresh_next;
            p1_valid_reg <= active_reg;
        end
    end

    always_ff @(posedge aclk) begin
        j_reg      <= j_next;
        p1_idx_reg <= j_reg;
        p1_use_reg <= use_slot;
    end

    // source slot min(j, deadline) - duration
    assign lim      = (j_reg < deadline) ? j_reg : deadline;
    assign use_slot = CMP_W'(lim) >= CMP_W'(duration);
    assign t_full   = CMP_W'(lim) - CMP_W'(duration);

    dj_ram #(
        .WIDTH (BW),
        .DEPTH (DEPTH)
    ) u_row (
        .aclk    (aclk),
        .we      (p1_valid_reg),
        .waddr   (p1_idx_reg),
        .wdata   (new_val),
        .raddr_a (j_reg),
        .rdata_a (rd_j),
        .raddr_b (t_full[IDX_W-1:0]),
        .rdata_b (rd_t)
    );

    // update stage: a fresh row reads as zero and every slot is rewritten
    assign old_val  = fresh_reg ? '0 : rd_j;
    assign base_val = fresh_reg ? '0 : rd_t;
    assign sum      = {1'b0, base_val} + (BW+1)'(profit);
    assign cand     = sum[BW] ? '1 : sum[BW-1:0];
    assign new_val  = (p1_use_reg && (cand > old_val)) ? cand : old_val;

    assign sts.last_issue = active_reg && (j_reg == '0);
    assign sts.top_wr     = p1_valid_reg && (p1_idx_reg == IDX_W'(HORIZON));
    assign top_value      = new_val;

endmodule

// ===== src/deadline_job_schedule_dp_unit.sv =====
`timescale 1ns / 1ps

// channel   ports                                                    direction
// request   s_valid s_ready s_profit s_deadline s_duration s_last    in
// result    m_valid m_ready m_best_profit m_deadline_clamped
//           m_order_error m_set_done                                 out
//
// a job in order: accept, a row sweep over all HORIZON+1 slots
// (one slot per cycle through the row memory's read/write ports), then the finish state
// a job out of order goes from accept to the finish state, the row is not touched
// no clearing pass after reset or after a last job: a row-fresh flag makes the next
// sweep read the row as zero and rewrite every slot
// a finished result waits in the output register; a new request is taken meanwhile,
// and the block holds in its finish cycle only while an earlier result is not taken

module deadline_job_schedule_dp_unit #(
    parameter int HORIZON = dj_pkg::DEF_HORIZON
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [dj_pkg::PROFIT_W-1:0]     s_profit,
    input  logic [dj_pkg::DEADLINE_W-1:0]   s_deadline,
    input  logic [dj_pkg::DURATION_W-1:0]   s_duration,
    input  logic                            s_last,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [dj_pkg::BEST_W-1:0]       m_best_profit,
    output logic                            m_deadline_clamped,
    output logic                            m_order_error,
    output logic                            m_set_done
);

    localparam int IDX_W = $clog2(HORIZON + 1);
    localparam int DLX_W = dj_pkg::DEADLINE_W + 1;

    dj_pkg::dj_state_t state_reg, state_next;

    // job registers, held for the whole sweep
    logic [dj_pkg::PROFIT_W-1:0]   job_profit_reg;
    logic [IDX_W-1:0]              job_dl_reg;
    logic [dj_pkg::DURATION_W-1:0] job_dur_reg;
    logic                          job_last_reg;
    logic                          job_clamp_reg;
    logic                          job_err_reg;

    // set state
    logic [IDX_W-1:0]              prev_dl_reg;
    logic                          fresh_reg;
    logic [dj_pkg::BEST_W-1:0]     best_top_reg;

    // output register
    logic                          m_valid_reg;
    logic [dj_pkg::BEST_W-1:0]     m_best_profit_reg;
    logic                          m_clamp_reg;
    logic                          m_err_reg;
    logic                          m_done_reg;

    logic                          accept;
    logic                          out_free;
    logic                          load;
    logic                          in_clamp;
    logic [IDX_W-1:0]              in_dl;
    logic                          in_err;

    dj_pkg::dj_sweep_ctl_t         sweep_ctl;
    dj_pkg::dj_sweep_sts_t         sweep_sts;
    logic [dj_pkg::BEST_W-1:0]     top_value;

    // clamp to the horizon, then check against the last deadline kept from an in-order job
    assign in_clamp = {1'b0, s_deadline} > DLX_W'(HORIZON);
    assign in_dl    = in_clamp ? IDX_W'(HORIZON) : s_deadline[IDX_W-1:0];
    assign in_err   = in_dl < prev_dl_reg;

    assign out_free = !m_valid_reg || m_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            dj_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = in_err ? dj_pkg::ST_DONE : dj_pkg::ST_SWEEP;
                end
            end
            dj_pkg::ST_SWEEP: begin
                if (sweep_sts.last_issue) begin
                    state_next = dj_pkg::ST_DONE;
                end
            end
            dj_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = dj_pkg::ST_IDLE;
                end
            end
            default: state_next = dj_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_ready = 1'b0;
        load    = 1'b0;
        unique case (state_reg)
            dj_pkg::ST_IDLE:  s_ready = 1'b1;
            dj_pkg::ST_SWEEP: s_ready = 1'b0;
            dj_pkg::ST_DONE:  load    = out_free;
            default:          s_ready = 1'b0;
        endcase
    end

    assign accept          = s_valid && s_ready;
    assign sweep_ctl.start = accept && !in_err;
    assign sweep_ctl.fresh = fresh_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= dj_pkg::ST_IDLE;
            prev_dl_reg  <= '0;
            fresh_reg    <= 1'b1;
            best_top_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;

            // top slot of the row tracked as it is written
            if (sweep_sts.top_wr) begin
                best_top_reg <= top_value;
            end

            if (load) begin
                m_valid_reg <= 1'b1;
                fresh_reg   <= job_last_reg;
                if (job_last_reg) begin
                    // end of set: row and deadline return to zero
                    prev_dl_reg  <= '0;
                    best_top_reg <= '0;
                end else if (!job_err_reg) begin
                    prev_dl_reg <= job_dl_reg;
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            job_profit_reg <= s_profit;
            job_dl_reg     <= in_dl;
            job_dur_reg    <= s_duration;
            job_last_reg   <= s_last;
            job_clamp_reg  <= in_clamp;
            job_err_reg    <= in_err;
        end
        if (load) begin
            m_best_profit_reg <= best_top_reg;
            m_clamp_reg       <= job_clamp_reg;
            m_err_reg         <= job_err_reg;
            m_done_reg        <= job_last_reg;
        end
    end

    dj_sweep #(
        .HORIZON (HORIZON)
    ) u_sweep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (sweep_ctl),
        .profit    (job_profit_reg),
        .deadline  (job_dl_reg),
        .duration  (job_dur_reg),
        .sts       (sweep_sts),
        .top_value (top_value)
    );

    assign m_valid            = m_valid_reg;
    assign m_best_profit      = m_best_profit_reg;
    assign m_deadline_clamped = m_clamp_reg;
    assign m_order_error      = m_err_reg;
    assign m_set_done         = m_done_reg;

endmodule

// ===== verif/tb_deadline_job_schedule_dp_unit.sv =====
`timescale 1ns / 1ps

module tb_deadline_job_schedule_dp_unit;

    // row length follows the block's default horizon
    localparam int HORIZON    = dj_pkg::DEF_HORIZON;
    localparam int JOB_TARGET = 580;
    // watch limit: eight in-order jobs plus a margin for stalls
    localparam int WATCH_LIMIT = 8 * (HORIZON + 3) + 500;

    // one job request as driven on the s_ side
    typedef struct packed {
        logic [dj_pkg::PROFIT_W-1:0]   profit;
        logic [dj_pkg::DEADLINE_W-1:0] deadline;
        logic [dj_pkg::DURATION_W-1:0] duration;
        logic                          last;
    } job_req_t;

    // one schedule result as seen on the m_ side
    typedef struct packed {
        logic [dj_pkg::BEST_W-1:0] best;
        logic                      clamped;
        logic                      order_err;
        logic                      done;
    } sched_result_t;

    // idling phases, stepped through as the jobs get accepted
    typedef enum logic [1:0] {
        PH_STEADY,
        PH_SEND_GAPS,
        PH_RECV_STALLS,
        PH_BOTH_IDLE
    } idle_phase_t;

    logic                            aclk    = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_valid = 1'b0;
    logic                            s_ready;
    logic [dj_pkg::PROFIT_W-1:0]     s_profit   = '0;
    logic [dj_pkg::DEADLINE_W-1:0]   s_deadline = '0;
    logic [dj_pkg::DURATION_W-1:0]   s_duration = '0;
    logic                            s_last     = 1'b0;
    logic                            m_valid;
    logic                            m_ready = 1'b0;
    logic [dj_pkg::BEST_W-1:0]       m_best_profit;
    logic                            m_deadline_clamped;
    logic                            m_order_error;
    logic                            m_set_done;

    // predictor state: the dp row and the last deadline kept from an in-order job
    logic [dj_pkg::BEST_W-1:0] row_best [0:HORIZON];
    int unsigned               prev_dl;

    job_req_t      pending_jobs[$];
    sched_result_t expected_q[$];

    int total_jobs    = 0;
    int jobs_accepted = 0;
    int results_seen  = 0;
    int sets_done     = 0;
    int clamp_count   = 0;
    int order_count   = 0;
    int fail_count    = 0;
    int idle_cycles   = 0;

    deadline_job_schedule_dp_unit u_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_profit           (s_profit),
        .s_deadline         (s_deadline),
        .s_duration         (s_duration),
        .s_last             (s_last),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_best_profit      (m_best_profit),
        .m_deadline_clamped (m_deadline_clamped),
        .m_order_error      (m_order_error),
        .m_set_done         (m_set_done)
    );

    always #5 aclk = ~aclk;

    // phase from progress through the job list
    function automatic idle_phase_t phase_now(input int accepted);
        if (total_jobs == 0)
            return PH_STEADY;
        case ((accepted * 4) / total_jobs)
            0: return PH_STEADY;
            1: return PH_SEND_GAPS;
            2: return PH_RECV_STALLS;
            default: return PH_BOTH_IDLE;
        endcase
    endfunction

    function automatic int send_idle_pct(input idle_phase_t ph);
        case (ph)
            PH_SEND_GAPS: return 52;
            PH_BOTH_IDLE: return 8;
            default:      return 0;
        endcase
    endfunction

    function automatic int recv_stall_pct(input idle_phase_t ph);
        case (ph)
            PH_RECV_STALLS: return 52;
            PH_BOTH_IDLE:   return 8;
            default:        return 0;
        endcase
    endfunction

    // applies one job to the predicted row and returns the result it gives
    function automatic sched_result_t schedule_job(input job_req_t job);
        sched_result_t res;
        int unsigned   dl;
        int unsigned   lim;
        logic [32:0]   cand;
        dl          = job.deadline;
        res.clamped = 1'b0;
        // large deadline is pulled down to the horizon
        if (dl > HORIZON) begin
            dl          = HORIZON;
            res.clamped = 1'b1;
        end
        // out of order job leaves row and previous deadline alone
        res.order_err = (dl < prev_dl);
        if (!res.order_err) begin
            // sweep high to low so each job is used at most once per slot
            for (int j = HORIZON; j >= 0; j--) begin
                lim = (j < dl) ? j : dl;
                if (lim >= job.duration) begin
                    cand = 33'(job.profit) + 33'(row_best[lim - job.duration]);
                    if (cand[32])
                        cand = 33'h0_FFFF_FFFF;
                    if (cand[31:0] > row_best[j])
                        row_best[j] = cand[31:0];
                end
            end
            prev_dl = dl;
        end
        res.best = row_best[HORIZON];
        res.done = job.last;
        // end of set: report first, then wipe the row
        if (job.last) begin
            foreach (row_best[i])
                row_best[i] = '0;
            prev_dl = 0;
        end
        return res;
    endfunction

    function automatic job_req_t make_job(input int profit, input int deadline,
                                          input int duration, input bit last);
        job_req_t job;
        job.profit   = profit[15:0];
        job.deadline = deadline[15:0];
        job.duration = duration[9:0];
        job.last     = last;
        return job;
    endfunction

    // appends one job to the pending list
    task automatic add_job(input int profit, input int deadline,
                           input int duration, input bit last);
        pending_jobs = {pending_jobs, make_job(profit, deadline, duration, last)};
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (exp_val !== act_val) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_val,
                     act_val);
            fail_count++;
        end
    endtask

    // driver: presents queued jobs, predicts each one as it is accepted
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_q = {expected_q, schedule_job({s_profit, s_deadline,
                                                        s_duration, s_last})};
                jobs_accepted <= jobs_accepted + 1;
            end
            // valid only drops or moves on once the current request is taken
            if (!s_valid || s_ready) begin
                if (pending_jobs.size() > 0 &&
                    $urandom_range(99) >= send_idle_pct(phase_now(jobs_accepted))) begin
                    job_req_t nxt;
                    nxt = pending_jobs.pop_front();
                    s_profit   <= nxt.profit;
                    s_deadline <= nxt.deadline;
                    s_duration <= nxt.duration;
                    s_last     <= nxt.last;
                    s_valid    <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: random back-pressure and in-order compare of every result
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got best %0d",
                             $time, m_best_profit);
                    fail_count++;
                end else begin
                    sched_result_t exp_res;
                    exp_res = expected_q.pop_front();
                    check_field("best_profit", exp_res.best, m_best_profit);
                    check_field("deadline_clamped", 32'(exp_res.clamped),
                                32'(m_deadline_clamped));
                    check_field("order_error", 32'(exp_res.order_err),
                                32'(m_order_error));
                    check_field("set_done", 32'(exp_res.done), 32'(m_set_done));
                    if (exp_res.clamped)
                        clamp_count++;
                    if (exp_res.order_err)
                        order_count++;
                    if (exp_res.done)
                        sets_done++;
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct(phase_now(jobs_accepted)));
        end
    end

    // watchdog: too long without any handshake means the block is stuck
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCH_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, WATCH_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        int set_len;
        int step;
        int gen_prev;
        int nxt_dl;
        int dl;
        int dur;
        int profit;
        int pick;

        foreach (row_best[i])
            row_best[i] = '0;
        prev_dl = 0;

        // directed set: zero profit and zero duration at slot 0, equal deadlines,
        // an out of order job, a job longer than every slot, a job fitting only
        // the top slot, clamped deadlines, and a last mark on a skipped job
        add_job(0, 0, 0, 0);
        add_job(65535, 0, 0, 0);
        add_job(1234, 5, 3, 0);
        add_job(777, 5, 0, 0);
        add_job(9, 2, 1, 0);
        add_job(40000, 600, 1023, 0);
        add_job(65535, HORIZON, 1023, 0);
        add_job(321, 65535, 512, 0);
        add_job(5, HORIZON + 1, 0, 0);
        add_job(65535, 100, 10, 1);
        // fresh set: deadline 0 is in order again, a job that fits nowhere
        add_job(1, 0, 1, 0);
        add_job(0, HORIZON, 0, 1);
        // single job set with a clamped deadline
        add_job(65535, 40000, 1, 1);
        // alternating bit patterns on every field
        add_job(16'hAAAA, 16'h0155, 10'h2AA, 0);
        add_job(16'h5555, 16'h02AA, 10'h155, 0);
        add_job(16'hAAAA, 16'h5555, 10'h3FF, 0);
        add_job(16'h5555, 16'hAAAA, 10'h000, 1);
        add_job(50, 0, 0, 1);

        // random sets: mostly sorted deadlines, some skipped jobs mixed in
        while (pending_jobs.size() < JOB_TARGET) begin
            set_len  = ($urandom_range(9) == 0) ? $urandom_range(40, 17)
                                                : $urandom_range(16, 1);
            step     = $urandom_range(300, 1);
            gen_prev = 0;
            for (int k = 0; k < set_len; k++) begin
                if (gen_prev > 0 && $urandom_range(99) < 8) begin
                    // noise: deadline below the last one kept
                    dl = $urandom_range(gen_prev - 1, 0);
                end else begin
                    nxt_dl = gen_prev + $urandom_range(step, 0);
                    if (nxt_dl > HORIZON) begin
                        dl       = $urandom_range(65535, HORIZON + 1);
                        gen_prev = HORIZON;
                    end else begin
                        dl       = nxt_dl;
                        gen_prev = nxt_dl;
                    end
                end
                pick = $urandom_range(99);
                if (pick < 60)
                    dur = $urandom_range(64, 0);
                else if (pick < 85)
                    dur = $urandom_range((gen_prev > 0) ? gen_prev : 1, 0);
                else
                    dur = $urandom_range(1023, 0);
                pick = $urandom_range(99);
                if (pick < 70)
                    profit = $urandom_range(65535, 0);
                else if (pick < 85)
                    profit = $urandom_range(15, 0);
                else
                    profit = $urandom_range(65535, 65000);
                add_job(profit, dl, dur, k == set_len - 1);
            end
        end
        total_jobs = pending_jobs.size();

        // reset held low at the start, released on a clock edge
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // all requests taken, then all results back
        while (jobs_accepted < total_jobs || expected_q.size() > 0)
            @(posedge aclk);
        // quiet tail to catch any stray result
        repeat (HORIZON + 8) @(posedge aclk);

        $display("ran %0d jobs and checked %0d results over %0d completed sets",
                 jobs_accepted, results_seen, sets_done);
        $display("results with clamped deadline: %0d, with order error: %0d",
                 clamp_count, order_count);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/dj_pkg.sv
src/dj_ram.sv
src/dj_sweep.sv
src/deadline_job_schedule_dp_unit.sv
verif/tb_deadline_job_schedule_dp_unit.sv
